/* hw/rtl/gbs_pkg.sv */
// ----------------------------------------------------------------------------
// gbs_pkg
// shared constants, types and helpers for the greedy box suppression core
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int IDX_W_DEF     = $clog2(MAX_BOXES_DEF);

  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int BOX_W   = 4 * COORD_W;
  localparam int WORD_W  = BOX_W + SCORE_W;

  localparam logic [15:0] THR_HALF  = 16'd32768;
  localparam logic [15:0] THR_RESET = 16'd32768;

  // register map, index = byte address / 4
  localparam logic REG_THRESHOLD = 1'b0;

  // result status of the overlap test pipeline
  typedef struct packed {
    logic valid;
    logic hit;
    logic busy;
  } iou_res_t;

  // clamped extent, zero when hi is not above lo
  function automatic logic [COORD_W-1:0] span16(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
    span16 = (hi > lo) ? (hi - lo) : '0;
  endfunction

endpackage

/* hw/rtl/gbs_iou.sv */
// ----------------------------------------------------------------------------
// gbs_iou
// pipelined overlap test: inter * 65536 > thr * union, without division
// ----------------------------------------------------------------------------
module gbs_iou import gbs_pkg::*; #(
  parameter int TAG_W = IDX_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [BOX_W-1:0] box_a,
  input  logic [BOX_W-1:0] box_b,
  input  logic [15:0]      thr,
  input  logic [TAG_W-1:0] in_tag,
  output iou_res_t         res,
  output logic [TAG_W-1:0] res_tag
);

  logic [COORD_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic [COORD_W-1:0] ix1, iy1, ix2, iy2;

  // stage 1: clamped spans
  logic               v1;
  logic [COORD_W-1:0] iw, ih, wa, ha, wb, hb;
  logic [TAG_W-1:0]   tag1;
  // stage 2: areas
  logic               v2;
  logic [31:0]        inter2, aa2, ab2;
  logic [TAG_W-1:0]   tag2;
  // stage 3: union
  logic               v3;
  logic [31:0]        inter3;
  logic [32:0]        uni3;
  logic [TAG_W-1:0]   tag3;
  // stage 4: scaled union
  logic               v4;
  logic [31:0]        inter4;
  logic [48:0]        prod4;
  logic               uz4;
  logic [TAG_W-1:0]   tag4;

  assign ax1 = box_a[15:0];
  assign ay1 = box_a[31:16];
  assign ax2 = box_a[47:32];
  assign ay2 = box_a[63:48];
  assign bx1 = box_b[15:0];
  assign by1 = box_b[31:16];
  assign bx2 = box_b[47:32];
  assign by2 = box_b[63:48];

  assign ix1 = (ax1 > bx1) ? ax1 : bx1;
  assign iy1 = (ay1 > by1) ? ay1 : by1;
  assign ix2 = (ax2 < bx2) ? ax2 : bx2;
  assign iy2 = (ay2 < by2) ? ay2 : by2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    iw   <= span16(ix1, ix2);
    ih   <= span16(iy1, iy2);
    wa   <= span16(ax1, ax2);
    ha   <= span16(ay1, ay2);
    wb   <= span16(bx1, bx2);
    hb   <= span16(by1, by2);
    tag1 <= in_tag;

    inter2 <= {16'b0, iw} * {16'b0, ih};
    aa2    <= {16'b0, wa} * {16'b0, ha};
    ab2    <= {16'b0, wb} * {16'b0, hb};
    tag2   <= tag1;

    inter3 <= inter2;
    uni3   <= {1'b0, aa2} + {1'b0, ab2} - {1'b0, inter2};
    tag3   <= tag2;

    inter4 <= inter3;
    prod4  <= {33'b0, thr} * {16'b0, uni3};
    uz4    <= (uni3 == '0);
    tag4   <= tag3;
  end

  assign res.valid = v4;
  assign res.hit   = !uz4 && ({1'b0, inter4, 16'h0000} > prod4);
  assign res.busy  = v1 | v2 | v3 | v4;
  assign res_tag   = tag4;

endmodule

/* hw/rtl/greedy_box_suppression_core.sv */
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// greedy iou non-maximum suppression over one set of up to MAX_BOXES boxes
// ----------------------------------------------------------------------------
// Boxes stream in one word per cycle until a word with tlast; boxes beyond
// MAX_BOXES are dropped and every result of that set carries the overflow
// flag in m_tuser. The set of n stored boxes is then ranked by counting, for
// each box, the boxes that beat it (higher score, or equal score and earlier
// arrival): one score memory read per cycle. The greedy pass walks the
// ranked list; each surviving box streams all later boxes through a
// four-stage overlap pipeline, one per cycle. Kept boxes then leave in rank
// order, each word held until m_tready takes it. The run time of a set is
// bound by the single read port of the score and rank memories. No word is
// taken on s_ while a set is in work or being emitted. The threshold register
// (Q0.16, zero means 0.5) is sampled on the tlast word.
// ----------------------------------------------------------------------------
module greedy_box_suppression_core import gbs_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input boxes
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,   // left_edge, top_edge, right_edge, bottom_edge, confidence
  input  logic              s_tlast,   // final_box
  // kept boxes
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,   // kept_left, kept_top, kept_right, kept_bottom, kept_score
  output logic              m_tlast,   // end_of_set
  output logic              m_tuser,   // overflowed
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_RANK_HEAD = 4'd1;
  localparam logic [3:0] ST_RANK_GET  = 4'd2;
  localparam logic [3:0] ST_RANK_SCAN = 4'd3;
  localparam logic [3:0] ST_NMS_HEAD  = 4'd4;
  localparam logic [3:0] ST_NMS_A     = 4'd5;
  localparam logic [3:0] ST_NMS_B     = 4'd6;
  localparam logic [3:0] ST_NMS_SCAN  = 4'd7;
  localparam logic [3:0] ST_EMIT_HEAD = 4'd8;
  localparam logic [3:0] ST_EMIT_A    = 4'd9;
  localparam logic [3:0] ST_EMIT_B    = 4'd10;
  localparam logic [3:0] ST_EMIT_WAIT = 4'd11;

  // box corners, scores and ranked order live in synchronous memories
  logic [BOX_W-1:0]   box_mem   [MAX_BOXES];
  logic [SCORE_W-1:0] score_mem [MAX_BOXES];
  logic [IDX_W-1:0]   rank_mem  [MAX_BOXES];

  logic [BOX_W-1:0]   box_q;
  logic [SCORE_W-1:0] score_q;
  logic [IDX_W-1:0]   rank_q;
  logic [IDX_W-1:0]   score_raddr, rank_raddr;

  logic [3:0]           state;
  logic [CNT_W-1:0]     count;
  logic                 ovf;
  logic [15:0]          thr_reg;
  logic [15:0]          thr_eff;
  logic [MAX_BOXES-1:0] removed;

  // ranking
  logic [CNT_W-1:0]   i, j;
  logic               rd_v;
  logic [IDX_W-1:0]   rd_j;
  logic [SCORE_W-1:0] score_i;
  logic [IDX_W-1:0]   rank_cnt;
  logic               beats;

  // greedy pass and emission
  logic [CNT_W-1:0] p, q;
  logic [IDX_W-1:0] a_idx, b_tag, last_kept;
  logic [BOX_W-1:0] box_a;
  logic             r1_v, r2_v;
  logic             last_pos;

  iou_res_t         iou_res;
  logic [IDX_W-1:0] iou_tag;

  logic in_acc, has_room, cfg_wr;

  assign s_tready = (state == ST_LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign has_room = (count < CNT_W'(MAX_BOXES));
  assign last_pos = ((p + CNT_W'(1)) == count);

  // config port, single threshold register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'h0000, thr_reg} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_reg <= THR_RESET;
    end else if (cfg_wr) begin
      thr_reg <= pwdata[15:0];
    end
  end

  // read address selection by phase
  always_comb begin
    unique case (state)
      ST_RANK_SCAN: score_raddr = j[IDX_W-1:0];
      ST_EMIT_A:    score_raddr = rank_q;
      default:      score_raddr = i[IDX_W-1:0];
    endcase
    unique case (state)
      ST_NMS_SCAN: rank_raddr = q[IDX_W-1:0];
      default:     rank_raddr = p[IDX_W-1:0];
    endcase
  end

  // memories: box corner address always follows the rank read of the cycle before
  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      box_mem[count[IDX_W-1:0]]   <= s_tdata[BOX_W-1:0];
      score_mem[count[IDX_W-1:0]] <= s_tdata[WORD_W-1:BOX_W];
    end
    if (state == ST_RANK_SCAN && j == count && !rd_v) begin
      rank_mem[rank_cnt] <= i[IDX_W-1:0];
    end
    box_q   <= box_mem[rank_q];
    score_q <= score_mem[score_raddr];
    rank_q  <= rank_mem[rank_raddr];
  end

  // a box beats the one being ranked on higher score, or equal score and earlier arrival
  assign beats = (score_q > score_i) ||
                 ((score_q == score_i) && (rd_j < i[IDX_W-1:0]));

  gbs_iou #(
    .TAG_W (IDX_W)
  ) u_iou (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r2_v),
    .box_a    (box_a),
    .box_b    (box_q),
    .thr      (thr_eff),
    .in_tag   (b_tag),
    .res      (iou_res),
    .res_tag  (iou_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      removed  <= '0;
      rd_v     <= 1'b0;
      r1_v     <= 1'b0;
      r2_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (iou_res.valid && iou_res.hit) begin
        removed[iou_tag] <= 1'b1;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              thr_eff <= (thr_reg == '0) ? THR_HALF : thr_reg;
              i       <= '0;
              state   <= ST_RANK_HEAD;
            end
          end
        end
        ST_RANK_HEAD: begin
          state <= ST_RANK_GET;
        end
        ST_RANK_GET: begin
          score_i  <= score_q;
          j        <= '0;
          rank_cnt <= '0;
          rd_v     <= 1'b0;
          state    <= ST_RANK_SCAN;
        end
        ST_RANK_SCAN: begin
          if (j < count) begin
            rd_v <= 1'b1;
            rd_j <= j[IDX_W-1:0];
            j    <= j + CNT_W'(1);
          end else begin
            rd_v <= 1'b0;
          end
          if (rd_v && beats) begin
            rank_cnt <= rank_cnt + IDX_W'(1);
          end
          if (j == count && !rd_v) begin
            i <= i + CNT_W'(1);
            if ((i + CNT_W'(1)) == count) begin
              p     <= '0;
              state <= ST_NMS_HEAD;
            end else begin
              state <= ST_RANK_HEAD;
            end
          end
        end
        ST_NMS_HEAD: begin
          state <= ST_NMS_A;
        end
        ST_NMS_A: begin
          a_idx <= rank_q;
          state <= ST_NMS_B;
        end
        ST_NMS_B: begin
          box_a <= box_q;
          if (!removed[a_idx]) begin
            last_kept <= p[IDX_W-1:0];
          end
          if (last_pos) begin
            p     <= '0;
            state <= ST_EMIT_HEAD;
          end else if (removed[a_idx]) begin
            p     <= p + CNT_W'(1);
            state <= ST_NMS_HEAD;
          end else begin
            q     <= p + CNT_W'(1);
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            state <= ST_NMS_SCAN;
          end
        end
        ST_NMS_SCAN: begin
          // rank read, then box read, then the overlap pipeline
          if (q < count) begin
            r1_v <= 1'b1;
            q    <= q + CNT_W'(1);
          end else begin
            r1_v <= 1'b0;
          end
          r2_v  <= r1_v;
          b_tag <= rank_q;
          if (q == count && !r1_v && !r2_v && !iou_res.busy) begin
            p     <= p + CNT_W'(1);
            state <= ST_NMS_HEAD;
          end
        end
        ST_EMIT_HEAD: begin
          state <= ST_EMIT_A;
        end
        ST_EMIT_A: begin
          a_idx <= rank_q;
          state <= ST_EMIT_B;
        end
        ST_EMIT_B: begin
          if (!removed[a_idx]) begin
            m_tdata  <= {score_q, box_q};
            m_tlast  <= (p[IDX_W-1:0] == last_kept);
            m_tuser  <= ovf;
            m_tvalid <= 1'b1;
            state    <= ST_EMIT_WAIT;
          end else begin
            p     <= p + CNT_W'(1);
            state <= ST_EMIT_HEAD;
          end
        end
        ST_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              // set done, back to an empty store
              count   <= '0;
              ovf     <= 1'b0;
              removed <= '0;
              state   <= ST_LOAD;
            end else begin
              p     <= p + CNT_W'(1);
              state <= ST_EMIT_HEAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // loading and emission never overlap
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  // the end-of-set word leaves the block empty and ready
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (count == '0 && s_tready && removed == '0))
    else $error("set not cleared after last word");

  // overlap results only arrive during the greedy scan
  assert property (@(posedge clk) disable iff (rst) iou_res.valid |-> state == ST_NMS_SCAN)
    else $error("stray overlap result");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for greedy_box_suppression_core
// ----------------------------------------------------------------------------
// Box sets stream into s_ and are mirrored into a local copy of the box store.
// On the tlast word the bench ranks the set, runs the greedy overlap walk,
// and queues the kept boxes that m_ must return in order. The threshold
// register is rewritten between phases, only while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import gbs_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [15:0] x1, y1, x2, y2, score;
    logic        last;
  } box_t;

  typedef struct {
    logic [15:0] x1, y1, x2, y2, score;
    logic        eos, ovf;
  } kept_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata = '0;   // left_edge, top_edge, right_edge, bottom_edge, confidence
  logic              s_tlast = 1'b0; // final_box
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;        // kept_left, kept_top, kept_right, kept_bottom, kept_score
  logic              m_tlast;        // end_of_set
  logic              m_tuser;        // overflowed
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  greedy_box_suppression_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bench copy of the core state
  box_t        box_queue[$];
  kept_t       kept_queue[$];
  box_t        stored[SLOTS];
  int          stored_count = 0;
  bit          dropped = 0;
  logic [15:0] threshold = THR_RESET;
  int          errors = 0;
  int          sets_out = 0;
  int          cycles = 0;

  function automatic longint unsigned span(longint unsigned lo, longint unsigned hi);
    return hi > lo ? hi - lo : 0;
  endfunction

  // true when b overlaps a by more than thr (Q0.16), division free
  function automatic bit overlap_exceeds(box_t a, box_t b, longint unsigned thr);
    longint unsigned iw, ih, inter, union_area;
    iw = span(a.x1 > b.x1 ? a.x1 : b.x1, a.x2 < b.x2 ? a.x2 : b.x2);
    ih = span(a.y1 > b.y1 ? a.y1 : b.y1, a.y2 < b.y2 ? a.y2 : b.y2);
    inter = iw * ih;
    union_area = span(a.x1, a.x2) * span(a.y1, a.y2) + span(b.x1, b.x2) * span(b.y1, b.y2)
                 - inter;
    if (union_area == 0) return 0;
    return (inter << 16) > thr * union_area;
  endfunction

  // rank by score (stable), greedy walk, queue the survivors
  function automatic void suppress_set();
    int              order[$];
    bit              gone[SLOTS];
    int              pos, a, b, kept;
    longint unsigned thr;
    kept_t           k;
    thr = threshold == 0 ? THR_HALF : threshold;
    for (int i = 0; i < stored_count; i++) begin
      pos = order.size();
      while (pos > 0 && stored[order[pos-1]].score < stored[i].score) pos--;
      order.insert(pos, i);
      gone[i] = 0;
    end
    kept = 0;
    for (int i = 0; i < stored_count; i++) begin
      a = order[i];
      if (gone[a]) continue;
      k = '{stored[a].x1, stored[a].y1, stored[a].x2, stored[a].y2, stored[a].score,
            1'b0, dropped};
      kept_queue = {kept_queue, k};
      kept++;
      for (int j = i + 1; j < stored_count; j++) begin
        b = order[j];
        if (!gone[b] && overlap_exceeds(stored[a], stored[b], thr)) gone[b] = 1;
      end
    end
    if (kept > 0) kept_queue[kept_queue.size()-1].eos = 1'b1;
    stored_count = 0;
    dropped = 0;
  endfunction

  function automatic void absorb_box(box_t bx);
    if (stored_count < SLOTS) begin
      stored[stored_count] = bx;
      stored_count++;
    end else begin
      dropped = 1;
    end
    if (bx.last) suppress_set();
  endfunction

  // quiet stretch: neither side idles at random here
  function automatic bit calm();
    return (cycles / 4000) % 4 == 1;
  endfunction

  // input driver
  always @(posedge clk) begin
    box_t bx;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        absorb_box('{s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48],
                     s_tdata[79:64], s_tlast});
      if (!s_tvalid || s_tready) begin
        if (box_queue.size() > 0 && (calm() || $urandom_range(0, 99) >= 7)) begin
          bx = box_queue.pop_front();
          s_tdata  <= {bx.score, bx.y2, bx.x2, bx.y1, bx.x1};
          s_tlast  <= bx.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output ready, with one long hold once a few sets are through
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && sets_out >= 6 && m_tvalid) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm() || $urandom_range(0, 99) >= 7;
    end
  end

  // result monitor
  always @(posedge clk) begin
    kept_t k;
    if (!rst && m_tvalid && m_tready) begin
      if (kept_queue.size() == 0) begin
        $display("%0t: unexpected word, actual %h last %b user %b", $time, m_tdata,
                 m_tlast, m_tuser);
        errors++;
      end else begin
        k = kept_queue.pop_front();
        if ({k.score, k.y2, k.x2, k.y1, k.x1} !== m_tdata || k.eos !== m_tlast ||
            k.ovf !== m_tuser) begin
          $display("%0t: mismatch, expected %h last %b user %b, actual %h last %b user %b",
                   $time, {k.score, k.y2, k.x2, k.y1, k.x1}, k.eos, k.ovf, m_tdata,
                   m_tlast, m_tuser);
          errors++;
        end
      end
      if (m_tlast) sets_out++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("greedy_box_suppression_core test failed");
      $finish;
    end
  end

  task automatic write_threshold(logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_THRESHOLD);
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    threshold = value;
  endtask

  task automatic push_box(int x1, int y1, int x2, int y2, int score, bit last);
    box_t bx;
    bx = '{16'(x1), 16'(y1), 16'(x2), 16'(y2), 16'(score), last};
    box_queue = {box_queue, bx};
  endtask

  // clustered boxes so that overlaps hit both sides of the threshold
  task automatic push_set(int n, bit wide);
    int cx, cy, w, h, x1, y1, sc;
    cx = $urandom_range(0, 64000);
    cy = $urandom_range(0, 64000);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          x1 = $urandom; y1 = $urandom; w = $urandom; h = $urandom;
          push_box(x1, y1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), i == n - 1);
          continue;
        end
        1: begin
          // inverted or flat box
          x1 = cx + $urandom_range(0, 400); y1 = cy + $urandom_range(0, 400);
          push_box(x1, y1, x1 - $urandom_range(0, 60), y1 + $urandom_range(0, 60),
                   $urandom_range(0, 65535), i == n - 1);
          continue;
        end
        default: begin
          x1 = cx + $urandom_range(0, wide ? 1000 : 80);
          y1 = cy + $urandom_range(0, wide ? 1000 : 80);
        end
      endcase
      w = $urandom_range(40, 500);
      h = $urandom_range(40, 500);
      sc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) * 21845 : $urandom_range(0, 65535);
      push_box(x1, y1, x1 + w > 65535 ? 65535 : x1 + w, y1 + h > 65535 ? 65535 : y1 + h,
               sc, i == n - 1);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (box_queue.size() > 0 || s_tvalid || kept_queue.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [15:0] settings[5];
    int n, sent;
    settings = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd20000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_threshold(settings[0]);
    // full-range box and an exact copy with the same score: copy goes
    push_box(0, 0, 65535, 65535, 65535, 0);
    push_box(0, 0, 65535, 65535, 65535, 0);
    // inverted box, lowest score
    push_box(100, 100, 50, 50, 0, 0);
    // two points: empty union, both stay
    push_box(10, 10, 10, 10, 30000, 0);
    push_box(10, 10, 10, 10, 30000, 0);
    push_box(65535, 65535, 65535, 65535, 1, 1);
    // single box set
    push_box(0, 0, 0, 0, 0, 1);
    // disjoint pair, then a set with a pair right at 0.5 and a box that the first removes
    push_box(0, 0, 16, 16, 500, 0);
    push_box(32, 32, 48, 48, 500, 1);
    push_box(0, 0, 30, 10, 900, 0);
    push_box(10, 0, 40, 10, 800, 0);
    push_box(0, 0, 20, 10, 800, 1);
    wait_idle();

    sent = 0;
    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_threshold(p == 4 ? 16'($urandom_range(1, 65535)) : settings[p]);
      for (int s = 0; s < 5; s++) begin
        // a full or overfull set in each phase, the first one queued behind a long output hold
        n = s == 3 ? $urandom_range(64, 68) : $urandom_range(1, 10);
        push_set(n, $urandom_range(0, 1));
        sent += n;
      end
      wait_idle();
    end
    write_threshold(settings[4]);
    while (sent < 450) begin
      n = $urandom_range(1, 12);
      push_set(n, $urandom_range(0, 1));
      sent += n;
    end
    wait_idle();

    if (errors == 0) begin
      $display("greedy_box_suppression_core test passed");
    end else begin
      $display("greedy_box_suppression_core test failed");
    end
    $finish;
  end

endmodule
